/* design/srb_pkg.sv */
// Shared types and constants for the stream byte reassembler.
package srb_pkg;

   // Ring store geometry
   localparam int WINDOW      = 64;
   localparam int RING_DEPTH  = 64;
   localparam int RING_AW     = 6;
   localparam int LIM_W       = 7;
   localparam int PEND_W      = 7;
   localparam int IDX_W       = 64;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = 1;
   localparam int QUEUE_CW    = 2;

   // Operation codes on the request side
   localparam logic [1:0] OP_DATA = 2'd0;
   localparam logic [1:0] OP_MARK = 2'd1;
   localparam logic [1:0] OP_SKIP = 2'd2;

   // Item classes handed from front to back
   localparam logic [1:0] CLS_DATA = 2'd0;
   localparam logic [1:0] CLS_MARK = 2'd1;
   localparam logic [1:0] CLS_SKIP = 2'd2;
   localparam logic [1:0] CLS_NONE = 2'd3;

   // Result kinds
   localparam logic KIND_STATUS = 1'b0;
   localparam logic KIND_BYTE   = 1'b1;

   // One classified item in the queue
   typedef struct packed {
      logic [1:0]       cls;
      logic [IDX_W-1:0] byte_index;
      logic [7:0]       data_byte;
      logic             final_flag;
      logic [LIM_W-1:0] lim;
   } item_type;

   // Queue handshake towards the back end
   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_out_type;

endpackage

/* design/srb_front.sv */
// Front end: takes request transfers, classifies them and queues them.
module srb_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [87:0]           req_tdata,
   input  logic [1:0]            req_tuser,
   input  logic                  req_tlast,
   output srb_pkg::queue_out_type q_out,
   input  logic                  q_pop
);
   import srb_pkg::*;

   item_type              queue_mem [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0]   count_ff, count_in;
   item_type              cls_item;
   logic                  push;
   logic                  pop;
   logic [15:0]           free_space;

   assign free_space = req_tdata[87:72];
   assign req_tready = (count_ff < QUEUE_CW'(QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready;
   assign pop        = q_pop && (count_ff != '0);

   // Classify the operation and clamp the free space to the window
   always_comb begin
      cls_item.byte_index = req_tdata[63:0];
      cls_item.data_byte  = req_tdata[71:64];
      cls_item.final_flag = req_tlast;
      if (free_space < 16'(WINDOW)) begin
         cls_item.lim = LIM_W'(free_space);
      end else begin
         cls_item.lim = LIM_W'(WINDOW);
      end
      case (req_tuser)
         OP_DATA: cls_item.cls = CLS_DATA;
         OP_MARK: cls_item.cls = CLS_MARK;
         OP_SKIP: cls_item.cls = CLS_SKIP;
         default: cls_item.cls = CLS_NONE;
      endcase
   end

   // Queue pointers
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         queue_mem[wr_ptr_ff] <= cls_item;
      end
   end

   assign q_out.valid = (count_ff != '0);
   assign q_out.item  = queue_mem[rd_ptr_ff];

endmodule

/* design/srb_back.sv */
// Back end: window checks, ring store, in-order drain and result register.
module srb_back (
   input  logic                  clock,
   input  logic                  reset,
   input  srb_pkg::queue_out_type q_out,
   output logic                  q_pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [15:0]           rsp_tdata,
   output logic                  rsp_tuser,
   output logic                  rsp_tlast
);
   import srb_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CHECK = 3'd1;
   localparam logic [2:0] S_APPLY = 3'd2;
   localparam logic [2:0] S_END   = 3'd3;
   localparam logic [2:0] S_RD    = 3'd4;
   localparam logic [2:0] S_EMIT  = 3'd5;
   localparam logic [2:0] S_STAT  = 3'd6;

   logic [2:0]            state_ff, state_in;
   item_type              item_ff, item_in;
   logic                  ok_ff, ok_in;
   logic [IDX_W-1:0]      next_index_ff, next_index_in;
   logic [PEND_W-1:0]     pending_ff, pending_in;
   logic                  end_known_ff, end_known_in;
   logic [IDX_W-1:0]      end_pos_ff, end_pos_in;
   logic                  closed_ff, closed_in;
   logic [RING_DEPTH-1:0] valid_ff, valid_in;
   logic [7:0]            rd_byte_ff;
   logic [7:0]            byte_ring [RING_DEPTH];

   logic                  rsp_valid_ff;
   logic                  rsp_kind_ff;
   logic [7:0]            rsp_byte_ff;
   logic                  rsp_closed_ff;
   logic [PEND_W-1:0]     rsp_pending_ff;
   logic                  rsp_last_ff;

   logic                  out_load;
   logic                  ld_kind;
   logic [7:0]            ld_byte;
   logic                  ld_closed;
   logic [PEND_W-1:0]     ld_pending;
   logic                  ld_last;

   logic                  mem_we;
   logic                  rd_en;
   logic                  out_free;
   logic                  at_end;
   logic [RING_AW-1:0]    slot_next;
   logic [RING_AW-1:0]    slot_item;
   logic [IDX_W-1:0]      diff;
   logic                  in_win;
   logic                  past_end;

   assign slot_next = next_index_ff[RING_AW-1:0];
   assign slot_item = item_ff.byte_index[RING_AW-1:0];
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign at_end    = end_known_ff && (next_index_ff == end_pos_ff);
   assign diff      = item_ff.byte_index - next_index_ff;
   assign in_win    = (item_ff.byte_index >= next_index_ff) &&
                      (diff < IDX_W'(item_ff.lim));
   assign past_end  = end_known_ff && (item_ff.byte_index >= end_pos_ff);

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      ok_in         = ok_ff;
      next_index_in = next_index_ff;
      pending_in    = pending_ff;
      end_known_in  = end_known_ff;
      end_pos_in    = end_pos_ff;
      closed_in     = closed_ff;
      valid_in      = valid_ff;
      q_pop         = 1'b0;
      mem_we        = 1'b0;
      rd_en         = 1'b0;
      out_load      = 1'b0;
      ld_kind       = KIND_STATUS;
      ld_byte       = '0;
      ld_closed     = closed_ff;
      ld_pending    = pending_ff;
      ld_last       = 1'b1;

      case (state_ff)
         S_IDLE: begin
            if (q_out.valid) begin
               item_in  = q_out.item;
               q_pop    = 1'b1;
               state_in = S_CHECK;
            end
         end

         // Window and end-of-stream test
         S_CHECK: begin
            ok_in    = in_win && !past_end;
            state_in = S_APPLY;
         end

         // Carry out the item
         S_APPLY: begin
            state_in = S_END;
            if (closed_ff) begin
               state_in = S_STAT;
            end else begin
               case (item_ff.cls)
                  CLS_SKIP: begin
                     if (valid_ff[slot_next]) begin
                        valid_in[slot_next] = 1'b0;
                        if (pending_ff != '0) begin
                           pending_in = pending_ff - 1'b1;
                        end
                     end
                     next_index_in = next_index_ff + 1'b1;
                  end
                  CLS_DATA: begin
                     if (ok_ff) begin
                        if (!valid_ff[slot_item]) begin
                           mem_we              = 1'b1;
                           valid_in[slot_item] = 1'b1;
                           pending_in          = pending_ff + 1'b1;
                        end
                        if (item_ff.final_flag && !end_known_ff) begin
                           end_known_in = 1'b1;
                           end_pos_in   = item_ff.byte_index + 1'b1;
                        end
                     end
                  end
                  CLS_MARK: begin
                     if (ok_ff && !end_known_ff) begin
                        end_known_in = 1'b1;
                        end_pos_in   = item_ff.byte_index;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         // Close if the end is reached, else see whether a drain starts
         S_END: begin
            if (at_end) begin
               closed_in  = 1'b1;
               valid_in   = '0;
               pending_in = '0;
               state_in   = S_STAT;
            end else if (valid_ff[slot_next]) begin
               state_in = S_RD;
            end else begin
               state_in = S_STAT;
            end
         end

         // Read the head byte and retire its slot
         S_RD: begin
            rd_en               = 1'b1;
            valid_in[slot_next] = 1'b0;
            if (pending_ff != '0) begin
               pending_in = pending_ff - 1'b1;
            end
            next_index_in = next_index_ff + 1'b1;
            state_in      = S_EMIT;
         end

         // Push the byte; the stream may close on it
         S_EMIT: begin
            if (out_free) begin
               out_load   = 1'b1;
               ld_kind    = KIND_BYTE;
               ld_byte    = rd_byte_ff;
               ld_closed  = at_end;
               ld_pending = at_end ? '0 : pending_ff;
               ld_last    = at_end || !valid_ff[slot_next];
               if (at_end) begin
                  closed_in  = 1'b1;
                  valid_in   = '0;
                  pending_in = '0;
               end
               state_in = ld_last ? S_IDLE : S_RD;
            end
         end

         S_STAT: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         ok_ff         <= 1'b0;
         next_index_ff <= '0;
         pending_ff    <= '0;
         end_known_ff  <= 1'b0;
         end_pos_ff    <= '0;
         closed_ff     <= 1'b0;
         valid_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         ok_ff         <= ok_in;
         next_index_ff <= next_index_in;
         pending_ff    <= pending_in;
         end_known_ff  <= end_known_in;
         end_pos_ff    <= end_pos_in;
         closed_ff     <= closed_in;
         valid_ff      <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   // Ring store, one write or one registered read a cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         byte_ring[slot_item] <= item_ff.data_byte;
      end
      if (rd_en) begin
         rd_byte_ff <= byte_ring[slot_next];
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_kind_ff    <= ld_kind;
         rsp_byte_ff    <= ld_byte;
         rsp_closed_ff  <= ld_closed;
         rsp_pending_ff <= ld_pending;
         rsp_last_ff    <= ld_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_pending_ff, rsp_closed_ff, rsp_byte_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

/* design/stream_byte_reassembler.sv */
// Top level of the stream byte reassembler.
//
// Request channel (req_*): one transfer per stream item. tuser carries the
// operation (data byte, empty final marker, skip one index), tlast the final
// mark, tdata the absolute byte index, the byte and the free space.
// Result channel (rsp_*): one transfer per byte pushed in order, or a single
// status transfer when an item pushes nothing; tlast marks the last result
// of each item, tuser says whether a byte is carried.
// A two-entry queue parts the request side from the sequencer, so requests
// are taken while a result waits. The sequencer works one item at a time:
// it checks and applies an item and tests for the end, then drains each byte
// from the 64-entry ring (one registered read, one result load), or loads
// a single status result. Once the stream is closed, the end check is skipped.
// Reset clears the valid marks, indexes and counts at once; no clearing
// pass is needed. When the receiver stalls, the result register holds and
// the sequencer waits; requests keep filling the queue until it is full.
module stream_byte_reassembler (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [87:0] req_tdata,  // byte_index[63:0], data_byte[71:64], free_space[87:72]
   input  logic [1:0]  req_tuser,  // operation[1:0]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // out_byte[7:0], stream_closed[8], pending_bytes[15:9]
   output logic        rsp_tuser,  // kind[0]
   output logic        rsp_tlast
);
   import srb_pkg::*;

   queue_out_type q_out;
   logic          q_pop;

   srb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .q_out      (q_out),
      .q_pop      (q_pop)
   );

   srb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_out      (q_out),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

/* design/srb_checker.sv */
// Port-level checks on the result channel, bound to the top level.
module srb_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        rsp_tlast
);
   import srb_pkg::*;

   logic seen_closed_ff;

   // Remember a transfer that reported the stream closed
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_closed_ff <= 1'b0;
      end else if (rsp_tvalid && rsp_tready && rsp_tdata[8]) begin
         seen_closed_ff <= 1'b1;
      end
   end

   // Stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) &&
                                       $stable(rsp_tuser) && $stable(rsp_tlast)))
      else $error("result changed while stalled");

   // A status result always ends its run
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == KIND_STATUS) |-> rsp_tlast)
      else $error("status result without last mark");

   // Once closed, only closed status results follow
   a_after_close: assert property (@(posedge clock) disable iff (reset)
      (seen_closed_ff && rsp_tvalid) |-> (rsp_tdata[8] && rsp_tuser == KIND_STATUS))
      else $error("activity after stream close");

   // A closed stream holds nothing
   a_closed_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[8]) |-> (rsp_tdata[15:9] == '0))
      else $error("pending bytes on a closed stream");

   // Pending count never exceeds the ring
   a_pending_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[15:9] <= PEND_W'(RING_DEPTH)))
      else $error("pending count beyond ring depth");

endmodule

bind stream_byte_reassembler srb_checker u_srb_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
